[rtl/mexp_pkg.sv]
// Shared widths, register indexes and datapath command/status types for modular exponentiation.
package mexp_pkg;

	// Bits of base and exponent taken into account.
	localparam int DATA_WIDTH = 32;

	localparam int BASE_W  = 32;
	localparam int EXP_W   = 32;
	localparam int MOD_W   = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Base reduction takes one quotient bit per cycle.
	localparam int DIV_STEPS = BASE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [BASE_W-1:0] DATA_MASK = (DATA_WIDTH >= BASE_W) ? '1 :
		BASE_W'((64'd1 << DATA_WIDTH) - 64'd1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture base, exponent, start reduction
		logic div_step;    // one restoring division step
		logic sq_load;     // square <= reduced base
		logic mul_init;    // start a modular product
		logic mul_sel_sq;  // multiplicand: 1 = square, 0 = running result
		logic mul_step;    // one shift-and-add step
		logic wr_acc;      // running result <= product
		logic wr_sq;       // square <= product
		logic exp_shift;   // next exponent bit
		logic out_load;    // load the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic mul_done;
		logic exp_zero;
		logic exp_lsb;
		logic exp_last;
		logic out_full;
	} dp_sts_t;

endpackage

[rtl/mexp_if.sv]
// Valid/ready channel interfaces for the input, result and configuration ports.
interface mexp_in_if;
	logic                        valid;
	logic                        ready;
	logic [mexp_pkg::BASE_W-1:0] base;

	modport source (output valid, output base, input ready);
	modport sink   (input valid, input base, output ready);
endinterface

interface mexp_out_if;
	logic                       valid;
	logic                       ready;
	logic [mexp_pkg::MOD_W-1:0] power_mod;

	modport source (output valid, output power_mod, input ready);
	modport sink   (input valid, input power_mod, output ready);
endinterface

interface mexp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mexp_pkg::CFG_IDX_W-1:0]  index;
	logic [mexp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/modular_exponentiation.sv]
// Top level: modular exponentiation core, base^exponent mod modulus, square-and-multiply.
//
//  channel  modport  payload            transfer
//  req      sink     base[31:0]         req.valid && req.ready
//  rsp      source   power_mod[30:0]    rsp.valid && rsp.ready
//  cfg      sink     index[0], data     cfg.valid && cfg.ready (always ready)
//
// One base at a time: base reduction first (one bit per cycle on the
// restoring divider), then per exponent bit up to two modular products on the
// single shift-and-add unit, each stepping through the multiplier's bits.
// Reset (arst_n low) clears the controller and sets exponent 0, modulus 1.
// A finished result waits in the output register; the next base is taken
// meanwhile and stalls only when its own result is ready before rsp drains.
module modular_exponentiation (
	input  logic       clk,
	input  logic       arst_n,
	mexp_in_if.sink    req,
	mexp_out_if.source rsp,
	mexp_cfg_if.sink   cfg
);
	import mexp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mexp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.base      (req.base),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.power_mod (rsp.power_mod)
	);
endmodule

[rtl/mexp_dp.sv]
// Datapath: config registers, base reduction, shared shift-and-add modular multiplier, output register.
module mexp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mexp_pkg::dp_cmd_t               cmd,
	output mexp_pkg::dp_sts_t               sts,
	input  logic [mexp_pkg::BASE_W-1:0]     base,
	input  logic                            cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mexp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [mexp_pkg::MOD_W-1:0]      power_mod
);
	import mexp_pkg::*;

	logic [EXP_W-1:0]  exponent_q;
	logic [MOD_W-1:0]  modulus_q;

	logic [BASE_W-1:0] num_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MOD_W-1:0]  rem_q;
	logic [MOD_W-1:0]  dbl_q;
	logic [MOD_W-1:0]  y_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  sq_q;
	logic [EXP_W-1:0]  exp_q;
	logic              out_valid_q;
	logic [MOD_W-1:0]  result_q;

	logic [MOD_W:0]    mod_ext;
	logic [MOD_W:0]    div_shift;
	logic [MOD_W-1:0]  div_next;
	logic [MOD_W:0]    add_sum;
	logic [MOD_W-1:0]  add_next;
	logic [MOD_W:0]    dbl_shift;
	logic [MOD_W-1:0]  dbl_next;
	logic              mod_small;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q  <= MOD_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_MODULUS:  modulus_q  <= cfg_data[MOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign mod_ext   = {1'b0, modulus_q};
	assign mod_small = (modulus_q <= MOD_W'(1));

	// Restoring division step: remainder stays below the modulus
	always_comb begin
		div_shift = {rem_q, num_q[BASE_W-1]};
		if (div_shift >= mod_ext)
			div_next = MOD_W'(div_shift - mod_ext);
		else
			div_next = div_shift[MOD_W-1:0];
	end

	// Shift-and-add step: add and double, each reduced by one subtract
	always_comb begin
		add_sum = {1'b0, rem_q} + {1'b0, dbl_q};
		if (add_sum >= mod_ext)
			add_next = MOD_W'(add_sum - mod_ext);
		else
			add_next = add_sum[MOD_W-1:0];
		dbl_shift = {dbl_q, 1'b0};
		if (dbl_shift >= mod_ext)
			dbl_next = MOD_W'(dbl_shift - mod_ext);
		else
			dbl_next = dbl_shift[MOD_W-1:0];
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= base & DATA_MASK;
			exp_q <= exponent_q & DATA_MASK;
			rem_q <= '0;
			cnt_q <= '0;
			acc_q <= MOD_W'(1);
		end else if (cmd.div_step) begin
			num_q <= {num_q[BASE_W-2:0], 1'b0};
			rem_q <= div_next;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.sq_load)
			sq_q <= rem_q;
		if (cmd.wr_acc)
			acc_q <= rem_q;
		if (cmd.wr_sq)
			sq_q <= rem_q;
		if (cmd.exp_shift)
			exp_q <= {1'b0, exp_q[EXP_W-1:1]};
		if (cmd.mul_init) begin
			rem_q <= '0;
			dbl_q <= cmd.mul_sel_sq ? sq_q : acc_q;
			y_q   <= sq_q;
		end else if (cmd.mul_step) begin
			if (y_q[0])
				rem_q <= add_next;
			dbl_q <= dbl_next;
			y_q   <= {1'b0, y_q[MOD_W-1:1]};
		end
		if (cmd.out_load)
			result_q <= mod_small ? '0 : acc_q;
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign power_mod = result_q;

	assign sts.div_done = (cnt_q == CNT_W'(DIV_STEPS));
	assign sts.mul_done = (y_q == '0);
	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_lsb  = exp_q[0];
	assign sts.exp_last = (exp_q[EXP_W-1:1] == '0);
	assign sts.out_full = out_valid_q && !out_ready;

`ifndef SYNTHESIS
	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) && !mod_small |-> rem_q < modulus_q)
		else $error("division remainder not below modulus");
	a_mul_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.mul_step) && !mod_small && $past(rem_q < modulus_q)
		&& $past(dbl_q < modulus_q) |-> rem_q < modulus_q && dbl_q < modulus_q)
		else $error("product accumulator left the residue range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && !cmd.out_load |=> $stable(result_q))
		else $error("pending result changed");
`endif
endmodule

[rtl/mexp_ctrl.sv]
// Controller: sequences base reduction and the square-and-multiply loop over the exponent bits.
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mexp_pkg::dp_sts_t sts,
	output mexp_pkg::dp_cmd_t cmd
);
	import mexp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_LOOP = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       phase_sq_q, phase_sq_d;

	// Next state and commands
	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		phase_sq_d = phase_sq_q;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.sq_load = 1'b1;
					state_d     = S_LOOP;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_LOOP: begin
				if (sts.exp_zero) begin
					state_d = S_FIN;
				end else begin
					// set bit: multiply first, else go straight to the square
					cmd.mul_init   = 1'b1;
					cmd.mul_sel_sq = !sts.exp_lsb;
					phase_sq_d     = !sts.exp_lsb;
					state_d        = S_MUL;
				end
			end
			S_MUL: begin
				if (!sts.mul_done) begin
					cmd.mul_step = 1'b1;
				end else if (!phase_sq_q) begin
					cmd.wr_acc = 1'b1;
					if (sts.exp_last) begin
						// last bit: the square is never used
						cmd.exp_shift = 1'b1;
						state_d       = S_LOOP;
					end else begin
						cmd.mul_init   = 1'b1;
						cmd.mul_sel_sq = 1'b1;
						phase_sq_d     = 1'b1;
					end
				end else begin
					cmd.wr_sq     = 1'b1;
					cmd.exp_shift = 1'b1;
					state_d       = S_LOOP;
				end
			end
			S_FIN: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_sq_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_sq_q <= phase_sq_d;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full)
		else $error("result loaded over a pending one");
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DIV)
		else $error("accepted base did not start reduction");
	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_acc || cmd.wr_sq |-> sts.mul_done && state_q == S_MUL)
		else $error("product written before multiply finished");
`endif
endmodule
